/* rtl/bcpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpi_pkg
// Shared types, constants and helpers of the box collision push and
// integrate block.
// ----------------------------------------------------------------------------
package bcpi_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ONE_FIX   = 1 << FRAC_BITS;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned GAIN_SHIFT = 15;
  localparam int unsigned PEN_W    = 35;
  localparam int unsigned MAG_W    = 34;
  localparam int unsigned SAT_W    = 36;
  localparam int unsigned MUL_W    = 33;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned THR2_W   = 2 * THR_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 136;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(ONE_FIX);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1 << GAIN_SHIFT);
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'((ONE_FIX + 500) / 1000);

  typedef enum logic [1:0] {
    CMD_BLOCK = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_SETV  = 2'd2,
    CMD_ADDV  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BODY_WIDTH  = 3'd0,
    CFG_BODY_HEIGHT = 3'd1,
    CFG_OFFSET_X    = 3'd2,
    CFG_OFFSET_Y    = 3'd3,
    CFG_FRICTION    = 3'd4,
    CFG_STOP_THR    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic pen;
    logic mag;
    logic sel;
    logic vel;
    logic tpos;
    logic tfx;
    logic tfy;
    logic tthr;
    logic tsqx;
    logic tstop;
    logic out_load;
  } dp_ctrl_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(POS_W-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end
    return v[POS_W-1:0];
  endfunction

endpackage

/* rtl/bcpi_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpi_ctrl
// Sequencer that walks one item at a time through the datapath steps and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module bcpi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bcpi_pkg::cmd_e    in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bcpi_pkg::dp_ctrl_t ctrl_o
);
  import bcpi_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_PEN   = 12'b0000_0000_0010,
    ST_MAG   = 12'b0000_0000_0100,
    ST_SEL   = 12'b0000_0000_1000,
    ST_VEL   = 12'b0000_0001_0000,
    ST_TPOS  = 12'b0000_0010_0000,
    ST_TFX   = 12'b0000_0100_0000,
    ST_TFY   = 12'b0000_1000_0000,
    ST_TTHR  = 12'b0001_0000_0000,
    ST_TSQX  = 12'b0010_0000_0000,
    ST_TSTOP = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load_out;

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_BLOCK: state_d = ST_PEN;
            CMD_TICK:  state_d = ST_TPOS;
            default:   state_d = ST_VEL;
          endcase
        end
      end
      ST_PEN:   state_d = ST_MAG;
      ST_MAG:   state_d = ST_SEL;
      ST_SEL:   state_d = ST_DONE;
      ST_VEL:   state_d = ST_DONE;
      ST_TPOS:  state_d = ST_TFX;
      ST_TFX:   state_d = ST_TFY;
      ST_TFY:   state_d = ST_TTHR;
      ST_TTHR:  state_d = ST_TSQX;
      ST_TSQX:  state_d = ST_TSTOP;
      ST_TSTOP: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign ctrl_o.load     = (state_q == ST_IDLE) && in_valid_i;
  assign ctrl_o.pen      = (state_q == ST_PEN);
  assign ctrl_o.mag      = (state_q == ST_MAG);
  assign ctrl_o.sel      = (state_q == ST_SEL);
  assign ctrl_o.vel      = (state_q == ST_VEL);
  assign ctrl_o.tpos     = (state_q == ST_TPOS);
  assign ctrl_o.tfx      = (state_q == ST_TFX);
  assign ctrl_o.tfy      = (state_q == ST_TFY);
  assign ctrl_o.tthr     = (state_q == ST_TTHR);
  assign ctrl_o.tsqx     = (state_q == ST_TSQX);
  assign ctrl_o.tstop    = (state_q == ST_TSTOP);
  assign ctrl_o.out_load = load_out;

endmodule

/* rtl/bcpi_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpi_dp
// Datapath: configuration registers, body state, penetration and push
// logic, shared multiplier for friction and stop test, result register.
// ----------------------------------------------------------------------------
module bcpi_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bcpi_pkg::dp_ctrl_t                   ctrl_i,
  input  logic                                 cfg_we_i,
  input  logic [bcpi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcpi_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  bcpi_pkg::cmd_e                       cmd_i,
  input  logic signed [bcpi_pkg::POS_W-1:0]    value_x_i,
  input  logic signed [bcpi_pkg::POS_W-1:0]    value_y_i,
  input  logic [bcpi_pkg::SIZE_W-1:0]          box_width_i,
  input  logic [bcpi_pkg::SIZE_W-1:0]          box_height_i,
  input  logic                                 is_trigger_i,
  output logic signed [bcpi_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [bcpi_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [bcpi_pkg::POS_W-1:0]    vel_x_o,
  output logic signed [bcpi_pkg::POS_W-1:0]    vel_y_o,
  output bcpi_pkg::dir_e                       push_dir_o
);
  import bcpi_pkg::*;

  function automatic logic signed [POS_W-1:0] scale_gain(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    b = p + (p[PROD_W-1] ? {{(PROD_W-GAIN_SHIFT){1'b0}}, {GAIN_SHIFT{1'b1}}} : '0);
    b = b >>> GAIN_SHIFT;
    return sat32(b[SAT_W-1:0]);
  endfunction

  logic [SIZE_W-1:0]        body_w_q, body_h_q;
  logic signed [POS_W-1:0]  off_x_q, off_y_q;
  logic [GAIN_W-1:0]        gain_q;
  logic [THR_W-1:0]         thr_q;

  cmd_e                     cmd_q;
  logic signed [POS_W-1:0]  in_x_q, in_y_q;
  logic [SIZE_W-1:0]        in_w_q, in_h_q;
  logic                     trig_q;

  logic signed [POS_W-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [POS_W-1:0]  vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  dir_e                     dir_q, dir_d;

  logic signed [PEN_W-1:0]  pen_l_q, pen_r_q, pen_b_q, pen_t_q;
  logic [MAG_W-1:0]         mag_l_q, mag_r_q, mag_b_q, mag_t_q;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [THR2_W-1:0]        thr2_q;
  logic [PROD_W-2:0]        acc_q;

  logic signed [POS_W-1:0]  out_px_q, out_py_q, out_vx_q, out_vy_q;
  dir_e                     out_dir_q;

  // Penetration terms.
  logic signed [PEN_W-1:0]  ox, oy, bhw, bhh, ohw, ohh, bx, by;
  always_comb begin
    bx  = PEN_W'(in_x_q);
    by  = PEN_W'(in_y_q);
    ox  = PEN_W'(pos_x_q) + PEN_W'(off_x_q);
    oy  = PEN_W'(pos_y_q) + PEN_W'(off_y_q);
    bhw = $signed({{(PEN_W-SIZE_W+1){1'b0}}, in_w_q[SIZE_W-1:1]});
    bhh = $signed({{(PEN_W-SIZE_W+1){1'b0}}, in_h_q[SIZE_W-1:1]});
    ohw = $signed({{(PEN_W-SIZE_W+1){1'b0}}, body_w_q[SIZE_W-1:1]});
    ohh = $signed({{(PEN_W-SIZE_W+1){1'b0}}, body_h_q[SIZE_W-1:1]});
  end

  // Shared multiplier.
  logic [POS_W-1:0]         abs_vx, abs_vy;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  always_comb begin
    abs_vx = vel_x_q[POS_W-1] ? POS_W'(-vel_x_q) : vel_x_q;
    abs_vy = vel_y_q[POS_W-1] ? POS_W'(-vel_y_q) : vel_y_q;
    unique if (ctrl_i.tpos) begin
      mul_a = MUL_W'(vel_x_q);
      mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_q});
    end else if (ctrl_i.tfx) begin
      mul_a = MUL_W'(vel_y_q);
      mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_q});
    end else if (ctrl_i.tfy) begin
      mul_a = $signed({{(MUL_W-THR_W){1'b0}}, thr_q});
      mul_b = $signed({{(MUL_W-THR_W){1'b0}}, thr_q});
    end else if (ctrl_i.tthr) begin
      mul_a = $signed({1'b0, abs_vx});
      mul_b = $signed({1'b0, abs_vx});
    end else if (ctrl_i.tsqx) begin
      mul_a = $signed({1'b0, abs_vy});
      mul_b = $signed({1'b0, abs_vy});
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
    mul_p  = mul_a * mul_b;
    prod_d = mul_p[PROD_W-1:0];
  end

  // Push selection, velocity commands and tick updates.
  logic             least_l, least_r, least_b, least_t;
  logic [PROD_W-1:0] m2;
  always_comb begin
    least_l = (mag_l_q < mag_r_q) && (mag_l_q < mag_b_q) && (mag_l_q < mag_t_q);
    least_r = (mag_r_q < mag_l_q) && (mag_r_q < mag_b_q) && (mag_r_q < mag_t_q);
    least_b = (mag_b_q < mag_l_q) && (mag_b_q < mag_r_q) && (mag_b_q < mag_t_q);
    least_t = (mag_t_q < mag_l_q) && (mag_t_q < mag_r_q) && (mag_t_q < mag_b_q);
    m2      = PROD_W'(acc_q) + PROD_W'(prod_q);
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    vel_x_d = vel_x_q;
    vel_y_d = vel_y_q;
    dir_d   = dir_q;
    if (ctrl_i.load) begin
      dir_d = DIR_NONE;
    end
    if (ctrl_i.sel && !trig_q) begin
      priority if (vel_x_q > 0 && least_l) begin
        pos_x_d = sat32(SAT_W'(pos_x_q) + SAT_W'(pen_l_q));
        dir_d   = DIR_LEFT;
      end else if (vel_x_q < 0 && least_r) begin
        pos_x_d = sat32(SAT_W'(pos_x_q) + SAT_W'(pen_r_q));
        dir_d   = DIR_RIGHT;
      end else if (vel_y_q > 0 && least_b) begin
        pos_y_d = sat32(SAT_W'(pos_y_q) + SAT_W'(pen_b_q));
        dir_d   = DIR_DOWN;
      end else if (vel_y_q < 0 && least_t) begin
        pos_y_d = sat32(SAT_W'(pos_y_q) + SAT_W'(pen_t_q));
        dir_d   = DIR_UP;
      end else begin
        dir_d   = DIR_NONE;
      end
    end
    if (ctrl_i.vel) begin
      if (cmd_q == CMD_SETV) begin
        vel_x_d = in_x_q;
        vel_y_d = in_y_q;
      end else begin
        vel_x_d = sat32(SAT_W'(vel_x_q) + SAT_W'(in_x_q));
        vel_y_d = sat32(SAT_W'(vel_y_q) + SAT_W'(in_y_q));
      end
    end
    if (ctrl_i.tpos) begin
      pos_x_d = sat32(SAT_W'(pos_x_q) + SAT_W'(vel_x_q));
      pos_y_d = sat32(SAT_W'(pos_y_q) + SAT_W'(vel_y_q));
    end
    if (ctrl_i.tfx) begin
      vel_x_d = scale_gain(prod_q);
    end
    if (ctrl_i.tfy) begin
      vel_y_d = scale_gain(prod_q);
    end
    if (ctrl_i.tstop && (m2 < PROD_W'(thr2_q))) begin
      vel_x_d = '0;
      vel_y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_w_q <= SIZE_RST;
      body_h_q <= SIZE_RST;
      off_x_q  <= '0;
      off_y_q  <= '0;
      gain_q   <= GAIN_RST;
      thr_q    <= THR_RST;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      dir_q    <= DIR_NONE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BODY_WIDTH:  body_w_q <= cfg_data_i[SIZE_W-1:0];
          CFG_BODY_HEIGHT: body_h_q <= cfg_data_i[SIZE_W-1:0];
          CFG_OFFSET_X:    off_x_q  <= cfg_data_i[POS_W-1:0];
          CFG_OFFSET_Y:    off_y_q  <= cfg_data_i[POS_W-1:0];
          CFG_FRICTION:    gain_q   <= cfg_data_i[GAIN_W-1:0];
          CFG_STOP_THR:    thr_q    <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      in_x_q <= value_x_i;
      in_y_q <= value_y_i;
      in_w_q <= box_width_i;
      in_h_q <= box_height_i;
      trig_q <= is_trigger_i;
    end
    if (ctrl_i.pen) begin
      pen_l_q <= (bx - bhw) - (ox + ohw);
      pen_r_q <= (bx + bhw) - (ox - ohw);
      pen_b_q <= (by - bhh) - (oy + ohh);
      pen_t_q <= (by + bhh) - (oy - ohh);
    end
    if (ctrl_i.mag) begin
      mag_l_q <= pen_l_q[PEN_W-1] ? MAG_W'(-pen_l_q) : MAG_W'(pen_l_q);
      mag_r_q <= pen_r_q[PEN_W-1] ? MAG_W'(-pen_r_q) : MAG_W'(pen_r_q);
      mag_b_q <= pen_b_q[PEN_W-1] ? MAG_W'(-pen_b_q) : MAG_W'(pen_b_q);
      mag_t_q <= pen_t_q[PEN_W-1] ? MAG_W'(-pen_t_q) : MAG_W'(pen_t_q);
    end
    prod_q <= prod_d;
    if (ctrl_i.tthr) begin
      thr2_q <= prod_q[THR2_W-1:0];
    end
    if (ctrl_i.tsqx) begin
      acc_q <= prod_q[PROD_W-2:0];
    end
    if (ctrl_i.out_load) begin
      out_px_q  <= pos_x_q;
      out_py_q  <= pos_y_q;
      out_vx_q  <= vel_x_q;
      out_vy_q  <= vel_y_q;
      out_dir_q <= dir_q;
    end
  end

  assign pos_x_o    = out_px_q;
  assign pos_y_o    = out_py_q;
  assign vel_x_o    = out_vx_q;
  assign vel_y_o    = out_vy_q;
  assign push_dir_o = out_dir_q;

endmodule

/* rtl/box_collision_push_and_integrate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_collision_push_and_integrate
// Keeps one body's position and velocity and applies blocker pushes, ticks
// and velocity commands.
// ----------------------------------------------------------------------------
// One item is processed at a time and every item gives one result transfer
// carrying the body state after the step. A blocker item passes through the
// penetration, magnitude and select steps, a set or add velocity item through
// the velocity step, and a tick through the position, friction, threshold,
// squared velocity and stop steps, in which the single shared multiplier in
// turn forms both friction products, the squared threshold and both squared
// velocity components. A finished result waits in the output register while
// the next item is accepted and worked on; the block stalls only when a
// second result is ready before the first has been taken. Configuration
// writes take effect at once and must be made while the block is idle.
module box_collision_push_and_integrate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bcpi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcpi_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // value_x[31:0], value_y[63:32], box_width[94:64], box_height[125:95], zero pad.
  input  logic [bcpi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // cmd[1:0], is_trigger[2].
  input  logic [bcpi_pkg::IN_USER_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], push_dir[130:128], zero pad.
  output logic [bcpi_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import bcpi_pkg::*;

  dp_ctrl_t                ctrl;
  cmd_e                    in_cmd;
  logic signed [POS_W-1:0] pos_x, pos_y, vel_x, vel_y;
  dir_e                    push_dir;

  assign in_cmd = cmd_e'(s_axis_tuser[1:0]);

  bcpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (in_cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  bcpi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (in_cmd),
    .value_x_i    (s_axis_tdata[31:0]),
    .value_y_i    (s_axis_tdata[63:32]),
    .box_width_i  (s_axis_tdata[94:64]),
    .box_height_i (s_axis_tdata[125:95]),
    .is_trigger_i (s_axis_tuser[2]),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .vel_x_o      (vel_x),
    .vel_y_o      (vel_y),
    .push_dir_o   (push_dir)
  );

  assign m_axis_tdata = {5'b0, push_dir, vel_y, vel_x, pos_y, pos_x};

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (push_dir == DIR_NONE || push_dir == DIR_LEFT ||
                       push_dir == DIR_RIGHT || push_dir == DIR_DOWN ||
                       push_dir == DIR_UP))
    else $error("push direction out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still in work");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl.out_load))
    else $error("result presented without a result register load");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten before transfer");

endmodule

/* bench/bcpi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpi_checker
// Watches the configuration port and both stream channels of the box
// collision block. It keeps its own copy of the body state and registers,
// predicts the body state for every accepted input transfer and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bcpi_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bcpi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcpi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [bcpi_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [bcpi_pkg::IN_USER_W-1:0]  s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [bcpi_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import bcpi_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    dir_e                    dir;
  } body_state_t;

  localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

  logic [SIZE_W-1:0]       body_w;
  logic [SIZE_W-1:0]       body_h;
  logic signed [POS_W-1:0] offset_x;
  logic signed [POS_W-1:0] offset_y;
  logic [GAIN_W-1:0]       friction;
  logic [THR_W-1:0]        stop_speed;

  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] vel_x;
  logic signed [POS_W-1:0] vel_y;

  body_state_t expected_q[$];
  int          fails;

  function automatic logic signed [POS_W-1:0] clip_s32(input longint v);
    if (v > S32_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      return 32'sh8000_0000;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit strictly_least(input longint a, input longint b, input longint c,
                                        input longint d);
    return (a < b) && (a < c) && (a < d);
  endfunction

  function automatic dir_e blocker_push(input logic signed [POS_W-1:0] cx_in,
                                        input logic signed [POS_W-1:0] cy_in,
                                        input logic [SIZE_W-1:0] bw, input logic [SIZE_W-1:0] bh,
                                        input logic trig);
    longint cx, cy, hw, hh, ox, oy, ohw, ohh;
    longint pl, pr, pb, pt, dl, dr, db, du;
    cx  = cx_in;
    cy  = cy_in;
    hw  = bw >> 1;
    hh  = bh >> 1;
    ohw = body_w >> 1;
    ohh = body_h >> 1;
    ox  = longint'(pos_x) + longint'(offset_x);
    oy  = longint'(pos_y) + longint'(offset_y);
    pl  = (cx - hw) - (ox + ohw);
    pr  = (cx + hw) - (ox - ohw);
    pb  = (cy - hh) - (oy + ohh);
    pt  = (cy + hh) - (oy - ohh);
    dl  = abs64(pl);
    dr  = abs64(pr);
    db  = abs64(pb);
    du  = abs64(pt);
    if (trig) begin
      return DIR_NONE;
    end
    if (vel_x > 0 && strictly_least(dl, dr, db, du)) begin
      pos_x = clip_s32(longint'(pos_x) + pl);
      return DIR_LEFT;
    end
    if (vel_x < 0 && strictly_least(dr, dl, db, du)) begin
      pos_x = clip_s32(longint'(pos_x) + pr);
      return DIR_RIGHT;
    end
    if (vel_y > 0 && strictly_least(db, dl, dr, du)) begin
      pos_y = clip_s32(longint'(pos_y) + pb);
      return DIR_DOWN;
    end
    if (vel_y < 0 && strictly_least(du, dl, dr, db)) begin
      pos_y = clip_s32(longint'(pos_y) + pt);
      return DIR_UP;
    end
    return DIR_NONE;
  endfunction

  function automatic void integrate_tick();
    longint          gain, fx, fy;
    longint unsigned ux, uy, m2, t2;
    pos_x = clip_s32(longint'(pos_x) + longint'(vel_x));
    pos_y = clip_s32(longint'(pos_y) + longint'(vel_y));
    gain  = friction;
    fx    = (longint'(vel_x) * gain) / 64'sd32768;
    fy    = (longint'(vel_y) * gain) / 64'sd32768;
    vel_x = clip_s32(fx);
    vel_y = clip_s32(fy);
    ux    = abs64(longint'(vel_x));
    uy    = abs64(longint'(vel_y));
    m2    = ux * ux + uy * uy;
    t2    = stop_speed;
    t2    = t2 * t2;
    if (m2 < t2) begin
      vel_x = '0;
      vel_y = '0;
    end
  endfunction

  function automatic body_state_t advance_body(input cmd_e cmd,
                                               input logic signed [POS_W-1:0] val_x,
                                               input logic signed [POS_W-1:0] val_y,
                                               input logic [SIZE_W-1:0] bw,
                                               input logic [SIZE_W-1:0] bh, input logic trig);
    body_state_t res;
    dir_e        dir;
    dir = DIR_NONE;
    case (cmd)
      CMD_BLOCK: begin
        dir = blocker_push(val_x, val_y, bw, bh, trig);
      end
      CMD_TICK: begin
        integrate_tick();
      end
      CMD_SETV: begin
        vel_x = val_x;
        vel_y = val_y;
      end
      default: begin
        vel_x = clip_s32(longint'(vel_x) + longint'(val_x));
        vel_y = clip_s32(longint'(vel_y) + longint'(val_y));
      end
    endcase
    res.pos_x = pos_x;
    res.pos_y = pos_y;
    res.vel_x = vel_x;
    res.vel_y = vel_y;
    res.dir   = dir;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    body_state_t got;
    body_state_t want;
    if (!rst_ni) begin
      body_w     = SIZE_RST;
      body_h     = SIZE_RST;
      offset_x   = '0;
      offset_y   = '0;
      friction   = GAIN_RST;
      stop_speed = THR_RST;
      pos_x      = '0;
      pos_y      = '0;
      vel_x      = '0;
      vel_y      = '0;
      fails      = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_BODY_WIDTH:  body_w     = cfg_data_i[SIZE_W-1:0];
          CFG_BODY_HEIGHT: body_h     = cfg_data_i[SIZE_W-1:0];
          CFG_OFFSET_X:    offset_x   = cfg_data_i;
          CFG_OFFSET_Y:    offset_y   = cfg_data_i;
          CFG_FRICTION:    friction   = cfg_data_i[GAIN_W-1:0];
          CFG_STOP_THR:    stop_speed = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got.pos_x = m_tdata_i[31:0];
        got.pos_y = m_tdata_i[63:32];
        got.vel_x = m_tdata_i[95:64];
        got.vel_y = m_tdata_i[127:96];
        got.dir   = dir_e'(m_tdata_i[130:128]);
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected result: 0x%h", m_tdata_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("vel_x", want.vel_x, got.vel_x);
          check_field("vel_y", want.vel_y, got.vel_y);
          check_field("push_dir", 32'(want.dir), 32'(got.dir));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(advance_body(cmd_e'(s_tuser_i[1:0]), s_tdata_i[31:0],
                                          s_tdata_i[63:32], s_tdata_i[94:64],
                                          s_tdata_i[125:95], s_tuser_i[2]));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
  end

endmodule

/* bench/tb_box_collision_push_and_integrate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_collision_push_and_integrate
// Drives the box collision block with a directed sequence covering every
// push side, ties, triggers, the stop test and saturation, then with
// random phases under changing register settings and random stalls on
// both channels. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_box_collision_push_and_integrate;
  import bcpi_pkg::*;

  localparam int ITEMS_PER_PHASE = 115;
  localparam int PHASE_COUNT     = 10;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 20;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    fail_count;
  int                    pending;
  bit                    steady;

  box_collision_push_and_integrate dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bcpi_checker body_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    int hold;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        m_axis_tready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  function automatic logic [31:0] rand_coord();
    int k;
    k = $urandom_range(0, 99);
    if (k < 85) begin
      return int'($urandom_range(0, 32'hC0000)) - 32'sh60000;
    end else if (k < 95) begin
      return $urandom;
    end
    case ($urandom_range(0, 2))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] rand_speed();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      return int'($urandom_range(0, 32'h40000)) - 32'sh20000;
    end else if (k < 85) begin
      return int'($urandom_range(0, 600)) - 300;
    end
    return $urandom;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) begin
      return SIZE_W'($urandom_range(0, 32'h40000));
    end else if (k < 95) begin
      return SIZE_W'($urandom);
    end
    return ($urandom_range(0, 1) == 0) ? '0 : '1;
  endfunction

  // Entered and left at a falling edge; the transfer happens at the last rising edge in between.
  task automatic send_item(input cmd_e cmd, input logic [31:0] val_x, input logic [31:0] val_y,
                           input logic [SIZE_W-1:0] bw, input logic [SIZE_W-1:0] bh,
                           input logic trig);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, bh, bw, val_y, val_x};
    s_axis_tuser  = {trig, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] w_set, h_set, bw, bh;
    logic [31:0]       ox_set, oy_set, vx, vy;
    logic [GAIN_W-1:0] g_set;
    logic [THR_W-1:0]  t_set;
    cmd_e              cmd;
    int                k;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    steady        = 1'b0;
    rst_ni        = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset settings, starting from the body at the origin.
    send_item(CMD_BLOCK, 32'h0, 32'h0, '0, '0, 1'b0);
    send_item(CMD_SETV, 32'h10000, 32'h0, '0, '0, 1'b0);
    send_item(CMD_BLOCK, 32'hC000, 32'h0, 31'h10000, 31'h10000, 1'b1);
    send_item(CMD_BLOCK, 32'hC000, 32'h0, 31'h10000, 31'h10000, 1'b0);
    send_item(CMD_BLOCK, -32'sh4000, 32'h0, 31'h10000, 31'h10000, 1'b0);
    send_item(CMD_SETV, -32'sh10000, 32'h0, '0, '0, 1'b0);
    send_item(CMD_BLOCK, 32'h20000, 32'h0, 31'h10000, 31'h10000, 1'b0);
    send_item(CMD_BLOCK, -32'sh10000, 32'h0, 31'h10000, 31'h10000, 1'b0);
    send_item(CMD_SETV, 32'h0, 32'h10000, '0, '0, 1'b0);
    send_item(CMD_BLOCK, 32'h0, 32'hC000, 31'h10000, 31'h10000, 1'b0);
    send_item(CMD_SETV, 32'h0, -32'sh10000, '0, '0, 1'b0);
    send_item(CMD_BLOCK, 32'h0, -32'sh10000, 31'h10000, 31'h10000, 1'b0);
    send_item(CMD_SETV, 32'd66, 32'h0, '0, '0, 1'b0);
    send_item(CMD_TICK, 32'h0, 32'h0, '0, '0, 1'b0);
    send_item(CMD_SETV, 32'd40, -32'sd40, '0, '0, 1'b0);
    send_item(CMD_TICK, 32'h0, 32'h0, '0, '0, 1'b0);
    send_item(CMD_SETV, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, 1'b1);
    send_item(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, 1'b1);
    send_item(CMD_TICK, 32'h0, 32'h0, '0, '0, 1'b0);
    send_item(CMD_ADDV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 1'b0);
    send_item(CMD_ADDV, 32'h8000_0000, 32'h8000_0000, '0, '0, 1'b0);
    send_item(CMD_BLOCK, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, 1'b0);
    send_item(CMD_BLOCK, 32'h7FFF_FFFF, 32'h8000_0000, '1, '0, 1'b0);
    send_item(CMD_TICK, 32'h0, 32'h0, '0, '0, 1'b0);
    wait_drained();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          w_set = '0; h_set = '0; ox_set = '0; oy_set = '0;
          g_set = 16'd32768; t_set = '0;
        end
        1: begin
          w_set = '1; h_set = '1; ox_set = 32'h7FFF_FFFF; oy_set = 32'h8000_0000;
          g_set = '0; t_set = '1;
        end
        2: begin
          w_set = 31'h10000; h_set = 31'h20000; ox_set = 32'h8000_0000;
          oy_set = 32'h7FFF_FFFF; g_set = 16'd32768; t_set = 16'd66;
        end
        default: begin
          w_set  = SIZE_W'($urandom_range(0, 32'h60000));
          h_set  = SIZE_W'($urandom_range(0, 32'h60000));
          if ($urandom_range(0, 3) == 0) begin
            w_set = SIZE_W'($urandom);
          end
          ox_set = int'($urandom_range(0, 32'h40000)) - 32'sh20000;
          oy_set = int'($urandom_range(0, 32'h40000)) - 32'sh20000;
          g_set  = GAIN_W'($urandom_range(28000, 32768));
          t_set  = THR_W'($urandom_range(0, 3000));
        end
      endcase
      write_reg(CFG_BODY_WIDTH, 32'(w_set));
      write_reg(CFG_BODY_HEIGHT, 32'(h_set));
      write_reg(CFG_OFFSET_X, ox_set);
      write_reg(CFG_OFFSET_Y, oy_set);
      write_reg(CFG_FRICTION, 32'(g_set));
      write_reg(CFG_STOP_THR, 32'(t_set));
      steady = (phase % 4 == 3);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        k = $urandom_range(0, 99);
        if (k < 45) begin
          cmd = CMD_BLOCK;
        end else if (k < 70) begin
          cmd = CMD_TICK;
        end else if (k < 85) begin
          cmd = CMD_SETV;
        end else begin
          cmd = CMD_ADDV;
        end
        vx = rand_coord();
        vy = rand_coord();
        bw = rand_size();
        bh = rand_size();
        if (cmd == CMD_SETV || cmd == CMD_ADDV) begin
          vx = rand_speed();
          vy = rand_speed();
        end
        send_item(cmd, vx, vy, bw, bh, $urandom_range(0, 6) == 0);
        if (phase == 4 && i == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bcpi_pkg.sv
rtl/bcpi_ctrl.sv
rtl/bcpi_dp.sv
rtl/box_collision_push_and_integrate.sv
bench/bcpi_checker.sv
bench/tb_box_collision_push_and_integrate.sv
